// ===== design/lpid_pkg.sv =====
// Shared types and defaults for the label pair id assigner.
package lpid_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int COUNT_WIDTH_DEF   = 16;

   typedef struct packed {
      logic               clear_first;
      logic signed [31:0] label_a;
      logic signed [31:0] label_b;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  pair_id;
      logic        first_seen;
      logic [15:0] pair_count;
      logic        table_full;
   } rsp_word_type;

   // Control bits that travel with a word along the cell chain.
   typedef struct packed {
      logic valid;
      logic clear;
      logic done;    // resolved: hit or inserted upstream
      logic first;   // resolved by insertion
   } cell_ctl_type;

endpackage

// ===== design/lpid_cell.sv =====
// One table entry of the chain: holds a key and its count, resolves a passing word.
module lpid_cell #(
   parameter int IDX     = 0,
   parameter int ID_W    = 8,
   parameter int COUNT_W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  lpid_pkg::cell_ctl_type ctl_i,
   input  logic [63:0]           key_i,
   input  logic [ID_W-1:0]       id_i,
   input  logic [COUNT_W-1:0]    cnt_i,
   output lpid_pkg::cell_ctl_type ctl_o,
   output logic [63:0]           key_o,
   output logic [ID_W-1:0]       id_o,
   output logic [COUNT_W-1:0]    cnt_o
);

   logic                   occ_ff, occ_in;
   logic [63:0]            key_ff, key_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in, cnt_sat;
   lpid_pkg::cell_ctl_type ctl_ff, ctl_in;
   logic [63:0]            pkey_ff;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [COUNT_W-1:0]     pcnt_ff, pcnt_in;
   logic                   occ_eff, match, ins;

   // a clearing word empties this entry before it is looked at
   assign occ_eff = occ_ff & ~(ctl_i.valid & ctl_i.clear);
   assign match   = ctl_i.valid & ~ctl_i.done & occ_eff & (key_ff == key_i);
   assign ins     = ctl_i.valid & ~ctl_i.done & ~occ_eff;
   assign cnt_sat = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;

   always_comb begin
      occ_in  = occ_eff | ins;
      key_in  = ins ? key_i : key_ff;
      cnt_in  = cnt_ff;
      if (ins) begin
         cnt_in = COUNT_W'(1);
      end else if (match) begin
         cnt_in = cnt_sat;
      end
      ctl_in       = ctl_i;
      ctl_in.done  = ctl_i.done | match | ins;
      ctl_in.first = ctl_i.first | ins;
      id_in        = (match | ins) ? ID_W'(IDX) : id_i;
      pcnt_in      = cnt_i;
      if (ins) begin
         pcnt_in = COUNT_W'(1);
      end else if (match) begin
         pcnt_in = cnt_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         occ_ff       <= occ_in;
         ctl_ff.valid <= ctl_in.valid;
         key_ff       <= key_in;
         cnt_ff       <= cnt_in;
         ctl_ff.clear <= ctl_in.clear;
         ctl_ff.done  <= ctl_in.done;
         ctl_ff.first <= ctl_in.first;
         pkey_ff      <= key_i;
         id_ff        <= id_in;
         pcnt_ff      <= pcnt_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign key_o = pkey_ff;
   assign id_o  = id_ff;
   assign cnt_o = pcnt_ff;

endmodule

// ===== design/label_pair_id_assigner_top.sv =====
// Top level: key ordering, chain of table cells and the response register.
// A word passes through every cell register, then the response register.
// Throughput: one word per cycle unless a stalled response holds the chain; each
// word steps one cell down the chain per advance and sees all updates ahead of it.
// Reset empties the table (all cells unoccupied) and drops words in flight;
// stored keys and counts keep their old bits but are never read unoccupied.
module label_pair_id_assigner_top #(
   parameter int TABLE_ENTRIES = lpid_pkg::TABLE_ENTRIES_DEF,
   parameter int COUNT_WIDTH   = lpid_pkg::COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lpid_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lpid_pkg::rsp_word_type rsp_data
);

   localparam int ID_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   lpid_pkg::cell_ctl_type ctl [0:TABLE_ENTRIES];
   logic [63:0]            key [0:TABLE_ENTRIES];
   logic [ID_W-1:0]        id  [0:TABLE_ENTRIES];
   logic [COUNT_WIDTH-1:0] cnt [0:TABLE_ENTRIES];

   logic                   adv;
   logic                   a_lt_b;
   logic                   rsp_valid_ff, rsp_valid_in;
   lpid_pkg::rsp_word_type rsp_data_ff, rsp_data_in;
   lpid_pkg::cell_ctl_type last;
   logic [ID_W+7:0]        id_ext;
   logic [COUNT_WIDTH+15:0] cnt_ext;

   assign adv       = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~adv;

   // smaller label in the low half
   assign a_lt_b = req_data.label_a < req_data.label_b;

   always_comb begin
      ctl[0].valid = req_valid;
      ctl[0].clear = req_data.clear_first;
      ctl[0].done  = 1'b0;
      ctl[0].first = 1'b0;
      key[0] = a_lt_b ? {req_data.label_b, req_data.label_a}
                      : {req_data.label_a, req_data.label_b};
      id[0]  = '0;
      cnt[0] = '0;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      lpid_cell #(
         .IDX     (i),
         .ID_W    (ID_W),
         .COUNT_W (COUNT_WIDTH)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .ctl_i (ctl[i]),
         .key_i (key[i]),
         .id_i  (id[i]),
         .cnt_i (cnt[i]),
         .ctl_o (ctl[i+1]),
         .key_o (key[i+1]),
         .id_o  (id[i+1]),
         .cnt_o (cnt[i+1])
      );
   end

   assign last    = ctl[TABLE_ENTRIES];
   assign id_ext  = {8'b0, id[TABLE_ENTRIES]};
   assign cnt_ext = {16'b0, cnt[TABLE_ENTRIES]};

   always_comb begin
      rsp_valid_in = last.valid;
      if (last.done) begin
         rsp_data_in.pair_id    = id_ext[7:0];
         rsp_data_in.first_seen = last.first;
         rsp_data_in.pair_count = cnt_ext[15:0];
         rsp_data_in.table_full = 1'b0;
      end else begin
         // no hit and no free cell anywhere down the chain
         rsp_data_in.pair_id    = '0;
         rsp_data_in.first_seen = 1'b0;
         rsp_data_in.pair_count = '0;
         rsp_data_in.table_full = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/lpid_check.sv =====
// Port-level checks for the label pair id assigner, bound to the top level.
module lpid_check (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input lpid_pkg::rsp_word_type rsp_data
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // a full-table response carries no id, count or first flag
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.table_full |->
         rsp_data.pair_id == 8'd0 && rsp_data.pair_count == 16'd0 && !rsp_data.first_seen)
      else $error("full response with nonzero fields");

   // a fresh insertion always reports count one
   a_first_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.first_seen |->
         rsp_data.pair_count == 16'd1 && !rsp_data.table_full)
      else $error("first sight with bad count");

   // reset drops any pending response
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // input is only held back by a stalled response
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind label_pair_id_assigner_top lpid_check u_lpid_check (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
